@@ design/peak_rms_level_meter_core_assert.svh @@
// assertion macros for the level meter core
// expects aclk and aresetn in the scope of the module that uses them
`ifndef PEAK_RMS_LEVEL_METER_CORE_ASSERT_SVH
`define PEAK_RMS_LEVEL_METER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PRLM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define PRLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/prlm_pkg.sv @@
// shared widths, state codes and helpers for the peak/rms level meter
// no dependencies
package prlm_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int PEAK_W     = 24;
    localparam int ROOT_W     = 24;
    localparam int COUNT_W    = 17;
    localparam int SQ_W       = 47;
    localparam int SUM_W      = 63;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int UNIT_W     = ROOT_W + 2;
    localparam int MAX_FRAMES = 65536;

    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int S_TDATA_W  = 24;
    localparam int M_FIELDS_W = PEAK_W + ROOT_W + COUNT_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    // absolute value of a two's complement sample, most negative value included
    function automatic logic [PEAK_W-1:0] magnitude(input logic [SAMPLE_W-1:0] raw);
        logic [PEAK_W-1:0] neg;
        neg = PEAK_W'(~raw) + PEAK_W'(1);
        if (raw[SAMPLE_W-1]) begin
            return neg;
        end
        return raw;
    endfunction

endpackage

@@ design/peak_rms_level_meter_core.sv @@
// peak / rms audio level meter, single module with a shared subtract unit
// depends on prlm_pkg and peak_rms_level_meter_core_assert.svh
//
// channel   dir  signals                          fields (low bit up)
// s_        in   s_tvalid s_tready s_tdata        tdata: sample[23:0]
//                s_tlast s_tuser                  tlast: last, tuser: no_data
// m_        out  m_tvalid m_tready m_tdata        tdata: peak[23:0] rms[47:24]
//                                                 frames[64:48] valid_res[65]
//
// a mid-block sample is accepted, squared and accumulated; a last sample then also
// runs the restoring divide, the square root and the output load; both loops share
// one 26-bit subtractor; a no_data item goes from accept straight to output load
// reset is synchronous active low and clears the state, accumulator, step and
// output-valid registers only; the output register holds a result while new samples
// are taken; the sequencer waits in output load only if the last result is not taken
`include "peak_rms_level_meter_core_assert.svh"

module peak_rms_level_meter_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [prlm_pkg::S_TDATA_W-1:0] s_tdata,   // sample[23:0]
    input  logic                           s_tlast,
    input  logic                           s_tuser,   // no_data
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [prlm_pkg::M_TDATA_W-1:0] m_tdata    // peak, rms, frames, valid_res
);
    import prlm_pkg::*;

    state_t                 state_reg, state_next;
    logic [PEAK_W-1:0]      mag_reg, mag_next;
    logic                   last_reg, last_next;
    logic                   keep_reg, keep_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [PEAK_W-1:0]      peak_reg, peak_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [UNIT_W-1:0]      work_reg, work_next;
    logic [SUM_W-1:0]       quo_reg, quo_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [PEAK_W-1:0]      snap_peak_reg, snap_peak_next;
    logic [COUNT_W-1:0]     snap_frames_reg, snap_frames_next;
    logic                   snap_valid_reg, snap_valid_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    logic [2*PEAK_W-1:0]    prod;
    logic [SUM_W-1:0]       sum_upd;
    logic [COUNT_W-1:0]     count_upd;
    logic [UNIT_W-1:0]      op_a, op_b;
    logic [UNIT_W:0]        diff;
    logic                   unit_ge;

    // squarer, registered before the accumulate
    assign prod = mag_reg * mag_reg;

    // accumulator update for a kept sample
    assign sum_upd   = sum_reg + {{(SUM_W-SQ_W){1'b0}}, sq_reg};
    assign count_upd = count_reg + COUNT_W'(1);

    // shared subtract unit: divide step or square-root step
    always_comb begin
        case (state_reg)
            ST_SQRT: begin
                op_a = {work_reg[UNIT_W-3:0], quo_reg[RAD_W-1 -: 2]};
                op_b = {root_reg, 2'b01};
            end
            default: begin
                op_a = {{(UNIT_W-COUNT_W-1){1'b0}}, work_reg[COUNT_W-1:0], quo_reg[SUM_W-1]};
                op_b = {{(UNIT_W-COUNT_W){1'b0}}, snap_frames_reg};
            end
        endcase
    end
    assign diff    = {1'b0, op_a} - {1'b0, op_b};
    assign unit_ge = ~diff[UNIT_W];

    // sequencer
    always_comb begin
        state_next       = state_reg;
        mag_next         = mag_reg;
        last_next        = last_reg;
        keep_next        = keep_reg;
        sq_next          = sq_reg;
        peak_next        = peak_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        work_next        = work_reg;
        quo_next         = quo_reg;
        root_next        = root_reg;
        step_next        = step_reg;
        snap_peak_next   = snap_peak_reg;
        snap_frames_next = snap_frames_reg;
        snap_valid_next  = snap_valid_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        s_tready         = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        // no data: clear and report an empty snapshot
                        peak_next        = '0;
                        sum_next         = '0;
                        count_next       = '0;
                        snap_peak_next   = '0;
                        snap_frames_next = '0;
                        snap_valid_next  = 1'b0;
                        root_next        = '0;
                        state_next       = ST_OUT;
                    end else begin
                        mag_next   = magnitude(s_tdata[SAMPLE_W-1:0]);
                        last_next  = s_tlast;
                        keep_next  = (count_reg < COUNT_W'(MAX_FRAMES));
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                sq_next = prod[SQ_W-1:0];
                if (keep_reg && (mag_reg > peak_reg)) begin
                    peak_next = mag_reg;
                end
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (keep_reg) begin
                    sum_next   = sum_upd;
                    count_next = count_upd;
                end
                if (last_reg) begin
                    // hand the block to the divider and clear accumulators
                    snap_peak_next   = peak_reg;
                    snap_frames_next = keep_reg ? count_upd : count_reg;
                    snap_valid_next  = 1'b1;
                    quo_next         = keep_reg ? sum_upd : sum_reg;
                    work_next        = '0;
                    root_next        = '0;
                    step_next        = '0;
                    peak_next        = '0;
                    sum_next         = '0;
                    count_next       = '0;
                    state_next       = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                // restoring divide, one quotient bit a cycle
                if (unit_ge) begin
                    work_next = diff[UNIT_W-1:0];
                end else begin
                    work_next = op_a;
                end
                quo_next  = {quo_reg[SUM_W-2:0], unit_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    work_next  = '0;
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                // digit-by-digit root, one result bit a cycle
                if (unit_ge) begin
                    work_next = diff[UNIT_W-1:0];
                end else begin
                    work_next = op_a;
                end
                root_next = {root_reg[ROOT_W-2:0], unit_ge};
                quo_next  = {quo_reg[SUM_W-3:0], 2'b00};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, snap_valid_reg,
                                   snap_frames_reg, root_reg, snap_peak_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            peak_reg    <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            peak_reg    <= peak_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mag_reg         <= mag_next;
        last_reg        <= last_next;
        keep_reg        <= keep_next;
        sq_reg          <= sq_next;
        work_reg        <= work_next;
        quo_reg         <= quo_next;
        root_reg        <= root_next;
        snap_peak_reg   <= snap_peak_next;
        snap_frames_reg <= snap_frames_next;
        snap_valid_reg  <= snap_valid_next;
        m_data_reg      <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    `PRLM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= COUNT_W'(MAX_FRAMES),
        "sample count above limit")
    `PRLM_ASSERT_NOW(a_invalid_zero, m_tvalid && !m_tdata[M_FIELDS_W-1],
        m_tdata[M_FIELDS_W-2:0] == '0, "invalid snapshot carries nonzero fields")
    `PRLM_ASSERT_NEXT(a_div_to_sqrt,
        state_reg == ST_DIV && step_reg == STEP_W'(DIV_STEPS - 1),
        state_reg == ST_SQRT, "divider did not hand over to root")
    `PRLM_ASSERT_NEXT(a_taken_drops, m_valid_reg && m_tready && state_reg != ST_OUT,
        !m_valid_reg, "taken result still shown")

endmodule

@@ verif/peak_rms_level_meter_checker.sv @@
// level meter checker: watches both stream channels, predicts each snapshot
// and compares it with the block's result items; depends on prlm_pkg
module peak_rms_level_meter_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [prlm_pkg::S_TDATA_W-1:0] s_tdata,   // sample[23:0]
    input  logic                           s_tlast,   // last
    input  logic                           s_tuser,   // no_data
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [prlm_pkg::M_TDATA_W-1:0] m_tdata,   // peak, rms, frames, valid_res
    output int                             mismatches,
    output int                             outstanding
);
    import prlm_pkg::*;

    localparam int RMS_LSB    = PEAK_W;
    localparam int FRAMES_LSB = PEAK_W + ROOT_W;
    localparam int VALID_BIT  = FRAMES_LSB + COUNT_W;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [PEAK_W-1:0]  peak;
        logic [ROOT_W-1:0]  rms;
        logic [COUNT_W-1:0] frames;
        logic               valid_res;
    } level_snapshot_t;

    level_snapshot_t    snapshots_due[$];
    logic [PEAK_W-1:0]  blk_peak;
    logic [SUM_W-1:0]   blk_energy;
    logic [COUNT_W-1:0] blk_count;
    int                 errs;

    // absolute value, the most negative sample maps to 2^23
    function automatic logic [PEAK_W-1:0] abs_level(input logic [SAMPLE_W-1:0] raw);
        if (raw[SAMPLE_W-1]) begin
            return PEAK_W'(0) - PEAK_W'(raw);
        end
        return PEAK_W'(raw);
    endfunction

    // floor of the square root, one bit at a time from the top
    function automatic logic [ROOT_W-1:0] floor_root(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) begin
                root = trial;
            end
        end
        return ROOT_W'(root);
    endfunction

    task automatic clear_block();
        blk_peak   = '0;
        blk_energy = '0;
        blk_count  = '0;
    endtask

    // update the running block state for one accepted item
    task automatic take_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
                               input logic nd);
        level_snapshot_t   snap;
        logic [PEAK_W-1:0] mag;
        logic [63:0]       mean;
        // no_data wins over last and drops the block
        if (nd) begin
            snap = '0;
            snapshots_due.push_back(snap);
            clear_block();
            return;
        end
        // samples past the frame limit are dropped
        if (blk_count < MAX_FRAMES) begin
            mag = abs_level(smp);
            if (mag > blk_peak) begin
                blk_peak = mag;
            end
            blk_energy = blk_energy + SUM_W'(64'(mag) * 64'(mag));
            blk_count  = blk_count + 1'b1;
        end
        if (!lst) begin
            return;
        end
        mean = (blk_count != 0) ? 64'(blk_energy) / 64'(blk_count) : 64'd0;
        snap.peak      = blk_peak;
        snap.rms       = floor_root(mean);
        snap.frames    = blk_count;
        snap.valid_res = 1'b1;
        snapshots_due.push_back(snap);
        clear_block();
    endtask

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        level_snapshot_t got;
        level_snapshot_t want;
        if (!aresetn) begin
            snapshots_due.delete();
            clear_block();
        end else begin
            if (s_tvalid && s_tready) begin
                take_sample(s_tdata, s_tlast, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                got.peak      = m_tdata[0 +: PEAK_W];
                got.rms       = m_tdata[RMS_LSB +: ROOT_W];
                got.frames    = m_tdata[FRAMES_LSB +: COUNT_W];
                got.valid_res = m_tdata[VALID_BIT];
                if (snapshots_due.size() == 0) begin
                    errs++;
                    if (errs <= REPORT_MAX) begin
                        $display("unexpected result: peak=%0d rms=%0d frames=%0d valid=%0b",
                                 got.peak, got.rms, got.frames, got.valid_res);
                    end
                end else begin
                    want = snapshots_due.pop_front();
                    if (got != want) begin
                        errs++;
                        if (errs <= REPORT_MAX) begin
                            $display("mismatch: expected peak=%0d rms=%0d frames=%0d valid=%0b",
                                     want.peak, want.rms, want.frames, want.valid_res);
                            $display("          actual   peak=%0d rms=%0d frames=%0d valid=%0b",
                                     got.peak, got.rms, got.frames, got.valid_res);
                        end
                    end
                end
            end
        end
        outstanding <= snapshots_due.size();
        mismatches  <= errs;
    end

endmodule

@@ verif/tb.sv @@
// testbench top for the peak/rms level meter: clock, reset, sample stimulus,
// receiver stalls and the verdict; depends on prlm_pkg and the checker module
module tb;
    import prlm_pkg::*;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int HOLD_CYCLES   = 1500;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 4000000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // sample[23:0]
    logic                 s_tlast;   // last
    logic                 s_tuser;   // no_data
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // peak[23:0] rms[47:24] frames[64:48] valid_res[65]

    int   mismatches;
    int   outstanding;
    logic calm;
    logic hold_req;
    int   burst_left;
    int   stall_left;
    int   cycle_cnt;

    peak_rms_level_meter_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    peak_rms_level_meter_checker level_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // mix of extremes, small values and full-range noise
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return SAMPLE_W'($urandom_range(0, 31));
            3: return SAMPLE_W'(0) - SAMPLE_W'($urandom_range(1, 32));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // offer one item at the falling edge, hold it until accepted
    task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic lst,
                             input logic nd);
        if (!calm && burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid = 1'b1;
        s_tdata  = smp;
        s_tlast  = lst;
        s_tuser  = nd;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge aclk);
    endtask

    // receiver: random stalls, calm stretches, and one long hold-off on request
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (calm) begin
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 40);
                end
            end
        end
    end

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("peak_rms_level_meter_core regression: fail");
        $finish;
    end

    initial begin
        int                  sent;
        int                  blk_len;
        logic                lst;
        logic                nd;
        logic [SAMPLE_W-2:0] r;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        s_tuser    = 1'b0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        burst_left = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // directed: one-sample blocks at the extremes and at zero
        send_item(SAMPLE_MAX, 1'b1, 1'b0);
        send_item(SAMPLE_MIN, 1'b1, 1'b0);
        send_item('0, 1'b1, 1'b0);
        // mixed-sign block with mid-block steps
        send_item(24'h000001, 1'b0, 1'b0);
        send_item(24'hFFFFFF, 1'b0, 1'b0);
        send_item(SAMPLE_MIN, 1'b0, 1'b0);
        send_item(SAMPLE_MAX, 1'b1, 1'b0);
        // no_data alone, then no_data overriding last in a partial block
        send_item(24'h123456, 1'b0, 1'b1);
        send_item(24'h400000, 1'b0, 1'b0);
        send_item(24'hC00000, 1'b0, 1'b0);
        send_item(SAMPLE_MAX, 1'b1, 1'b1);
        // fresh blocks after the clear
        send_item(24'h000010, 1'b1, 1'b0);
        send_item(24'h000003, 1'b0, 1'b0);
        send_item(24'hFFFFFD, 1'b0, 1'b0);
        send_item(24'h000004, 1'b1, 1'b0);
        send_item(24'h555555, 1'b0, 1'b0);
        send_item(24'hAAAAAA, 1'b1, 1'b0);

        // overlong block: kept samples stay within half scale, dropped ones are full scale
        calm = 1'b1;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            r = (SAMPLE_W-1)'($urandom);
            send_item({r[SAMPLE_W-2], r}, 1'b0, 1'b0);
        end
        send_item(SAMPLE_MIN, 1'b0, 1'b0);
        send_item(SAMPLE_MIN, 1'b0, 1'b0);
        send_item(SAMPLE_MIN, 1'b1, 1'b0);
        calm = 1'b0;

        // random blocks, mostly short, with no_data noise and early aborts
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                  : $urandom_range(1, 12);
            for (int k = 0; k < blk_len; k++) begin
                nd  = ($urandom_range(0, 29) == 0);
                lst = (k == blk_len - 1) ? 1'b1 : (nd && $urandom_range(0, 1) == 1);
                if (k == blk_len - 1 && $urandom_range(0, 9) == 0) begin
                    nd = 1'b1;
                end
                send_item(pick_sample(), lst, nd);
                sent++;
                if (sent == RANDOM_ITEMS / 3) begin
                    hold_req = 1'b1;
                end
                if (sent % 250 == 0) begin
                    calm = ($urandom_range(0, 2) == 0);
                end
            end
        end
        s_tvalid = 1'b0;

        // drain and verdict
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("peak_rms_level_meter_core regression: pass");
        end else begin
            $display("peak_rms_level_meter_core regression: fail");
        end
        $finish;
    end

endmodule

@@ peak_rms_level_meter_core.f @@
+incdir+design
design/prlm_pkg.sv
design/peak_rms_level_meter_core.sv
verif/peak_rms_level_meter_checker.sv
verif/tb.sv
